// File: rtl/usm_pkg.sv
// shared constants and types for the uv sphere mesh point block
package usm_pkg;

  localparam int CNT_W      = 9;
  localparam int RAD_W      = 16;
  localparam int POS_W      = 17;
  localparam int NRM_W      = 16;
  localparam int TEX_W      = 17;
  localparam int IDX_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_SEGMENTS_U_DEF = 256;
  localparam int MAX_SEGMENTS_V_DEF = 256;

  // divider: numerator 4*n*half_pi plus rounding, denominator up to 2*511
  localparam int DIV_NUM_W = 42;
  localparam int DIV_DEN_W = 10;
  localparam int DIV_LAT   = DIV_NUM_W;

  // residual angles and trig magnitudes, Q30
  localparam int TRIG_W    = 31;
  localparam int ANG_W     = 33;
  localparam int SIN_STEPS = 6;
  localparam int SIN_LAT   = 3 * SIN_STEPS + 3;
  localparam int SQ_W      = 32;
  localparam int RCP_W     = 30;

  localparam logic [TRIG_W-1:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [TRIG_W-1:0] HALF_PI_Q30 = 31'd1686629713;

  localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [RCP_W-1:0] SIN_RECIP [SIN_STEPS] = '{
    30'((64'd1 << 32) / 64'd156),
    30'((64'd1 << 32) / 64'd110),
    30'((64'd1 << 32) / 64'd72),
    30'((64'd1 << 32) / 64'd42),
    30'((64'd1 << 32) / 64'd20),
    30'((64'd1 << 32) / 64'd6)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEG_U     = 3'd0,
    CFG_SEG_V     = 3'd1,
    CFG_RADIUS    = 3'd2,
    CFG_MIRROR_S  = 3'd3,
    CFG_MIRROR_T  = 3'd4,
    CFG_INWARD    = 3'd5,
    CFG_REV_WIND  = 3'd6
  } cfg_idx_t;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

endpackage

// File: rtl/usm_if.sv
// item channels of the uv sphere mesh point block
interface usm_in_if;
  logic                      valid;
  logic                      ready;
  logic [usm_pkg::CNT_W-1:0] column;
  logic [usm_pkg::CNT_W-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink (input valid, input column, input row, output ready);
endinterface

interface usm_out_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic signed [usm_pkg::POS_W-1:0] pos_x;
  logic signed [usm_pkg::POS_W-1:0] pos_y;
  logic signed [usm_pkg::POS_W-1:0] pos_z;
  logic signed [usm_pkg::NRM_W-1:0] normal_x;
  logic signed [usm_pkg::NRM_W-1:0] normal_y;
  logic signed [usm_pkg::NRM_W-1:0] normal_z;
  logic [usm_pkg::TEX_W-1:0]        tex_s;
  logic [usm_pkg::TEX_W-1:0]        tex_t;
  logic [usm_pkg::IDX_W-1:0]        vertex_index;
  logic                             last;

  modport source (output valid, output kind, output pos_x, output pos_y, output pos_z,
                  output normal_x, output normal_y, output normal_z, output tex_s,
                  output tex_t, output vertex_index, output last, input ready);
  modport sink (input valid, input kind, input pos_x, input pos_y, input pos_z,
                input normal_x, input normal_y, input normal_z, input tex_s,
                input tex_t, input vertex_index, input last, output ready);
endinterface

// File: rtl/usm_div.sv
// pipelined restoring divider, one quotient bit per stage
module usm_div #(
  parameter int NUM_W = usm_pkg::DIV_NUM_W,
  parameter int DEN_W = usm_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  // numerator bits shift out at the top while quotient bits shift in below
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [NUM_W-1:0] num_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign num_in = num_i;
      assign rem_in = '0;
    end else begin : g_next
      assign num_in = num_r[s-1];
      assign rem_in = rem_r[s-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s] <= {num_in[NUM_W-2:0], ge};
        rem_r[s] <= ge ? DEN_W'(trial - {1'b0, den_i}) : DEN_W'(trial);
      end
    end
  end

  assign quo_o = num_r[NUM_W-1];

endmodule

// File: rtl/usm_sin.sv
// pipelined sine of a residual angle in Q30, horner series through x^13
module usm_sin (
  input  logic                       clk,
  input  logic                       en,
  input  logic [usm_pkg::TRIG_W-1:0] x_i,
  output logic [usm_pkg::TRIG_W-1:0] sin_o
);

  localparam int TW = usm_pkg::TRIG_W;
  localparam int NS = usm_pkg::SIN_STEPS;
  localparam int QW = usm_pkg::SQ_W;
  localparam int RW = usm_pkg::RCP_W;

  logic [2*TW-1:0] sq;
  logic [TW-1:0]   s0_x_r;
  logic [QW-1:0]   s0_x2_r;

  assign sq = (2*TW)'(x_i) * (2*TW)'(x_i);

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x_r  <= x_i;
      s0_x2_r <= QW'((sq + (2*TW)'(1 << 29)) >> 30);
    end
  end

  logic [TW-1:0] a_x_r  [NS];
  logic [QW-1:0] a_x2_r [NS];
  logic [QW-1:0] a_y_r  [NS];
  logic [TW-1:0] b_x_r  [NS];
  logic [QW-1:0] b_x2_r [NS];
  logic [QW-1:0] b_y_r  [NS];
  logic [RW-1:0] b_q_r  [NS];
  logic [TW-1:0] c_x_r  [NS];
  logic [QW-1:0] c_x2_r [NS];
  logic [TW-1:0] c_t_r  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [TW-1:0]      in_x;
    logic [QW-1:0]      in_x2;
    logic [TW-1:0]      in_t;
    logic [QW+TW-1:0]   prod;
    logic [QW+RW-1:0]   est;
    logic [QW:0]        resid;
    logic               fix;
    logic [TW-1:0]      quo;

    if (k == 0) begin : g_first
      assign in_x  = s0_x_r;
      assign in_x2 = s0_x2_r;
      assign in_t  = usm_pkg::ONE_Q30;
    end else begin : g_next
      assign in_x  = c_x_r[k-1];
      assign in_x2 = c_x2_r[k-1];
      assign in_t  = c_t_r[k-1];
    end

    // x2 * t in Q30
    assign prod = (QW+TW)'(in_x2) * (QW+TW)'(in_t);
    // quotient estimate by reciprocal, low by at most one
    assign est  = (QW+RW)'(a_y_r[k]) * (QW+RW)'(usm_pkg::SIN_RECIP[k]);
    // one correction step
    assign resid = (QW+1)'(b_y_r[k]) -
                   (QW+1)'(b_q_r[k]) * (QW+1)'(usm_pkg::SIN_DIV[k]);
    assign fix   = (resid >= (QW+1)'(usm_pkg::SIN_DIV[k]));
    assign quo   = TW'(b_q_r[k]) + TW'(fix);

    always_ff @(posedge clk) begin
      if (en) begin
        a_x_r[k]  <= in_x;
        a_x2_r[k] <= in_x2;
        a_y_r[k]  <= QW'(prod >> 30);
        b_x_r[k]  <= a_x_r[k];
        b_x2_r[k] <= a_x2_r[k];
        b_y_r[k]  <= a_y_r[k];
        b_q_r[k]  <= RW'(est >> 32);
        c_x_r[k]  <= b_x_r[k];
        c_x2_r[k] <= b_x2_r[k];
        c_t_r[k]  <= usm_pkg::ONE_Q30 - quo;
      end
    end
  end

  logic [2*TW-1:0] fin;
  logic [QW-1:0]   f_r;
  logic [TW-1:0]   out_r;

  assign fin = (2*TW)'(c_x_r[NS-1]) * (2*TW)'(c_t_r[NS-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      f_r   <= QW'((fin + (2*TW)'(1 << 29)) >> 30);
      out_r <= (f_r > QW'(usm_pkg::ONE_Q30)) ? usm_pkg::ONE_Q30 : TW'(f_r);
    end
  end

  assign sin_o = out_r;

endmodule

// File: rtl/uv_sphere_mesh_point_top.sv
// uv sphere mesh point generator: vertex attributes and cell triangle indices per grid point
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        column, row
//   out_ch   out  valid/ready        kind, pos_xyz, normal_xyz, tex_s/t, vertex_index, last
//   cfg_*    in   cfg_we (no wait)   cfg_index, cfg_data
//
// an item crosses a fixed pipeline of about 70 register stages (42 divider stages,
// 21 sine stages, the rest for quadrant, products and rounding) and lands in an emitter.
// the emitter sends 7 results for a cell point and 1 for an edge point, one per cycle while
// out_ch.ready is high, so the result channel sets the sustained item rate.
// the whole pipeline advances together; it holds only when the last stage is full and the
// emitter still has results pending. sync rst_n resets valids, emitter state and config.
module uv_sphere_mesh_point_top #(
  parameter int MAX_SEGMENTS_U = usm_pkg::MAX_SEGMENTS_U_DEF,
  parameter int MAX_SEGMENTS_V = usm_pkg::MAX_SEGMENTS_V_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  usm_in_if.sink                         in_ch,
  usm_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [usm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [usm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW   = usm_pkg::CNT_W;
  localparam int DNW  = usm_pkg::DIV_NUM_W;
  localparam int DDW  = usm_pkg::DIV_DEN_W;
  localparam int AW   = usm_pkg::ANG_W;
  localparam int TW   = usm_pkg::TRIG_W;
  localparam int PW   = usm_pkg::POS_W;
  localparam int NW   = usm_pkg::NRM_W;
  localparam int XW   = usm_pkg::TEX_W;
  localparam int IW   = usm_pkg::IDX_W;
  localparam int RDW  = usm_pkg::RAD_W;

  localparam int CNT_MAX = (1 << CW) - 1;
  localparam int CAP_U   = (MAX_SEGMENTS_U > CNT_MAX) ? CNT_MAX : MAX_SEGMENTS_U;
  localparam int CAP_V   = (MAX_SEGMENTS_V > CNT_MAX) ? CNT_MAX : MAX_SEGMENTS_V;

  // stage positions along the pipeline
  localparam int ST_Q = usm_pkg::DIV_LAT + 1;
  localparam int ST_R = ST_Q + usm_pkg::SIN_LAT + 1;
  localparam int ST_M = ST_R + 1;
  localparam int ST_N = ST_M + 1;
  localparam int ST_O = ST_N + 1;
  localparam int ST_W = ST_O + 1;
  localparam int TOT  = ST_W + 1;

  typedef struct packed {
    logic [CW-1:0] i;
    logic [CW-1:0] j;
    logic          in_grid;
    logic [2:0]    qt;
    logic [2:0]    qp;
    logic [XW-1:0] tex_s;
    logic [XW-1:0] tex_t;
  } side_t;

  typedef struct packed {
    logic [2:0]    q;
    logic [TW-1:0] x;
    logic [TW-1:0] xc;
  } ang_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } trig_t;

  // split a scaled angle into quadrant, residual and its complement
  function automatic ang_t quad_split(input logic [AW-1:0] xf);
    ang_t          a;
    logic [AW-1:0] h;
    begin
      h = AW'(usm_pkg::HALF_PI_Q30);
      if (xf >= AW'(4) * h)      a.q = 3'd4;
      else if (xf >= AW'(3) * h) a.q = 3'd3;
      else if (xf >= AW'(2) * h) a.q = 3'd2;
      else if (xf >= h)          a.q = 3'd1;
      else                       a.q = 3'd0;
      a.x  = TW'(xf - AW'(a.q) * h);
      a.xc = TW'(AW'(a.q + 3'd1) * h - xf);
      return a;
    end
  endfunction

  function automatic trig_t quad_map(input logic [2:0] q, input logic [TW-1:0] s0,
                                     input logic [TW-1:0] c0);
    trig_t              t;
    logic signed [31:0] ss;
    logic signed [31:0] cc;
    begin
      ss = $signed({1'b0, s0});
      cc = $signed({1'b0, c0});
      case (q[1:0])
        2'd0:    begin t.s = ss;  t.c = cc;  end
        2'd1:    begin t.s = cc;  t.c = -ss; end
        2'd2:    begin t.s = -ss; t.c = -cc; end
        default: begin t.s = -cc; t.c = ss;  end
      endcase
      return t;
    end
  endfunction

  // round half away from zero, then shift right
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] val,
                                                     input int sh);
    logic        neg;
    logic [63:0] mag;
    begin
      neg = val[63];
      mag = neg ? 64'(-val) : 64'(val);
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      return neg ? -$signed(mag) : $signed(mag);
    end
  endfunction

  // corner of the cell for each of the six triangle results
  function automatic logic [1:0] corner_sel(input logic rev, input logic [2:0] k);
    logic [1:0] c;
    begin
      case (k)
        3'd0:    c = 2'd0;
        3'd1:    c = rev ? 2'd1 : 2'd2;
        3'd2:    c = rev ? 2'd2 : 2'd1;
        3'd3:    c = 2'd1;
        3'd4:    c = rev ? 2'd3 : 2'd2;
        default: c = rev ? 2'd2 : 2'd3;
      endcase
      return c;
    end
  endfunction

  // configuration registers
  logic [CW-1:0]  seg_u_r, seg_v_r;
  logic [RDW-1:0] radius_r;
  logic           mirror_s_r, mirror_t_r, inward_r, rev_wind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_u_r    <= CW'(32);
      seg_v_r    <= CW'(16);
      radius_r   <= RDW'(256);
      mirror_s_r <= 1'b0;
      mirror_t_r <= 1'b0;
      inward_r   <= 1'b0;
      rev_wind_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (usm_pkg::cfg_idx_t'(cfg_index))
        usm_pkg::CFG_SEG_U:    seg_u_r    <= cfg_data[CW-1:0];
        usm_pkg::CFG_SEG_V:    seg_v_r    <= cfg_data[CW-1:0];
        usm_pkg::CFG_RADIUS:   radius_r   <= cfg_data[RDW-1:0];
        usm_pkg::CFG_MIRROR_S: mirror_s_r <= cfg_data[0];
        usm_pkg::CFG_MIRROR_T: mirror_t_r <= cfg_data[0];
        usm_pkg::CFG_INWARD:   inward_r   <= cfg_data[0];
        usm_pkg::CFG_REV_WIND: rev_wind_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective segment counts: zero reads as one, large counts saturate
  logic [CW-1:0] u_eff, v_eff;

  assign u_eff = (seg_u_r == '0) ? CW'(1) :
                 (seg_u_r > CW'(CAP_U)) ? CW'(CAP_U) : seg_u_r;
  assign v_eff = (seg_v_r == '0) ? CW'(1) :
                 (seg_v_r > CW'(CAP_V)) ? CW'(CAP_V) : seg_v_r;

  // pipeline control
  logic [TOT-1:0] vld_r;
  logic           en;
  logic           emit_take;

  assign en          = !vld_r[ST_W] || emit_take;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], in_ch.valid};
    end
  end

  // input stage: clamp, then build the four dividends
  logic [CW-1:0]  i_cl, j_cl, sn, tn;
  logic [CW+1:0]  i4, j4;
  logic [DNW-1:0] num_t_r, num_p_r, num_s_r, num_v_r;
  side_t          side_in, side_q;
  side_t          side_r [TOT];

  assign i_cl = (in_ch.column > u_eff) ? u_eff : in_ch.column;
  assign j_cl = (in_ch.row > v_eff) ? v_eff : in_ch.row;
  assign sn   = mirror_s_r ? u_eff - i_cl : i_cl;
  assign tn   = mirror_t_r ? v_eff - j_cl : j_cl;
  assign i4   = {i_cl, 2'b00};
  assign j4   = {j_cl, 2'b00};

  always_comb begin
    side_in         = '0;
    side_in.i       = i_cl;
    side_in.j       = j_cl;
    side_in.in_grid = (i_cl < u_eff) && (j_cl < v_eff);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // theta = i/u turn, phi = j/(2v) turn, both scaled so quadrant and residual
      // fall out of one quotient
      num_t_r <= DNW'(i4) * DNW'(usm_pkg::HALF_PI_Q30) + DNW'(u_eff >> 1);
      num_p_r <= DNW'(j4) * DNW'(usm_pkg::HALF_PI_Q30) + DNW'(v_eff);
      num_s_r <= DNW'({sn, 17'b0}) + DNW'(u_eff);
      num_v_r <= DNW'({tn, 17'b0}) + DNW'(v_eff);
    end
  end

  // dividers
  logic [DNW-1:0] quo_t, quo_p, quo_s, quo_v;
  logic [DDW-1:0] den_u, den_2u, den_2v;

  assign den_u  = DDW'(u_eff);
  assign den_2u = DDW'({u_eff, 1'b0});
  assign den_2v = DDW'({v_eff, 1'b0});

  usm_div #(.NUM_W(DNW), .DEN_W(DDW)) u_div_theta (
    .clk(clk), .en(en), .num_i(num_t_r), .den_i(den_u), .quo_o(quo_t)
  );
  usm_div #(.NUM_W(DNW), .DEN_W(DDW)) u_div_phi (
    .clk(clk), .en(en), .num_i(num_p_r), .den_i(den_2v), .quo_o(quo_p)
  );
  usm_div #(.NUM_W(DNW), .DEN_W(DDW)) u_div_tex_s (
    .clk(clk), .en(en), .num_i(num_s_r), .den_i(den_2u), .quo_o(quo_s)
  );
  usm_div #(.NUM_W(DNW), .DEN_W(DDW)) u_div_tex_t (
    .clk(clk), .en(en), .num_i(num_v_r), .den_i(den_2v), .quo_o(quo_v)
  );

  // quadrant stage
  ang_t          ang_t_c, ang_p_c;
  logic [TW-1:0] x_t_r, xc_t_r, x_p_r, xc_p_r;

  assign ang_t_c = quad_split(quo_t[AW-1:0]);
  assign ang_p_c = quad_split(quo_p[AW-1:0]);

  always_comb begin
    side_q       = side_r[ST_Q-1];
    side_q.qt    = ang_t_c.q;
    side_q.qp    = ang_p_c.q;
    side_q.tex_s = quo_s[XW-1:0];
    side_q.tex_t = quo_v[XW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_t_r  <= ang_t_c.x;
      xc_t_r <= ang_t_c.xc;
      x_p_r  <= ang_p_c.x;
      xc_p_r <= ang_p_c.xc;
    end
  end

  // side data travels with the item, picking up quadrants and texcoords on the way
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int k = 1; k < TOT; k++) begin
        side_r[k] <= (k == ST_Q) ? side_q : side_r[k-1];
      end
    end
  end

  // sine lanes: sin of residual and of its complement for each angle
  logic [TW-1:0] s0_t, c0_t, s0_p, c0_p;

  usm_sin u_sin_t  (.clk(clk), .en(en), .x_i(x_t_r),  .sin_o(s0_t));
  usm_sin u_cos_t  (.clk(clk), .en(en), .x_i(xc_t_r), .sin_o(c0_t));
  usm_sin u_sin_p  (.clk(clk), .en(en), .x_i(x_p_r),  .sin_o(s0_p));
  usm_sin u_cos_p  (.clk(clk), .en(en), .x_i(xc_p_r), .sin_o(c0_p));

  // quadrant unfold
  trig_t              tt_c, tp_c;
  logic signed [31:0] st_r, ct_r, sp_r, cp_r;

  assign tt_c = quad_map(side_r[ST_R-1].qt, s0_t, c0_t);
  assign tp_c = quad_map(side_r[ST_R-1].qp, s0_p, c0_p);

  // products, rounding and scaling by radius
  logic signed [63:0]    prod_c_r, prod_s_r;
  logic signed [31:0]    cp_m_r, cp_n_r, px_r, pz_r;
  logic signed [63:0]    nx_c, ny_c, nz_c;
  logic signed [NW-1:0]  nx_r, ny_r, nz_r, nx_o_r, ny_o_r, nz_o_r;
  logic signed [RDW:0]   rad_s;
  logic signed [RDW+32:0] mx_r, my_r, mz_r;
  logic [2*CW:0]         a_o_r;
  logic [PW-1:0]         pos_x_w_r, pos_y_w_r, pos_z_w_r;
  logic [NW-1:0]         nx_w_r, ny_w_r, nz_w_r;
  logic [IW-1:0]         a_w_r, c_w_r;

  assign nx_c  = round_shift(prod_c_r, 46);
  assign ny_c  = round_shift(64'(cp_m_r), 16);
  assign nz_c  = round_shift(prod_s_r, 46);
  assign rad_s = $signed({1'b0, radius_r});

  always_ff @(posedge clk) begin
    if (en) begin
      // unfold
      st_r <= tt_c.s;
      ct_r <= tt_c.c;
      sp_r <= tp_c.s;
      cp_r <= tp_c.c;
      // sin phi times cos/sin theta
      prod_c_r <= 64'(sp_r) * 64'(ct_r);
      prod_s_r <= 64'(sp_r) * 64'(st_r);
      cp_m_r   <= cp_r;
      // unit vector back to Q30, normals to Q1.14
      px_r   <= 32'(round_shift(prod_c_r, 30));
      pz_r   <= 32'(round_shift(prod_s_r, 30));
      cp_n_r <= cp_m_r;
      nx_r   <= NW'(inward_r ? -nx_c : nx_c);
      ny_r   <= NW'(inward_r ? -ny_c : ny_c);
      nz_r   <= NW'(inward_r ? -nz_c : nz_c);
      // times radius
      mx_r   <= (RDW+33)'(px_r) * (RDW+33)'(rad_s);
      my_r   <= (RDW+33)'(cp_n_r) * (RDW+33)'(rad_s);
      mz_r   <= (RDW+33)'(pz_r) * (RDW+33)'(rad_s);
      nx_o_r <= nx_r;
      ny_o_r <= ny_r;
      nz_o_r <= nz_r;
      a_o_r  <= (2*CW+1)'(side_r[ST_O-1].i) *
                ((2*CW+1)'(v_eff) + (2*CW+1)'(1)) +
                (2*CW+1)'(side_r[ST_O-1].j);
      // final rounding to Q8.8, corner base indices
      pos_x_w_r <= PW'(round_shift(64'(mx_r), 30));
      pos_y_w_r <= PW'(round_shift(64'(my_r), 30));
      pos_z_w_r <= PW'(round_shift(64'(mz_r), 30));
      nx_w_r    <= nx_o_r;
      ny_w_r    <= ny_o_r;
      nz_w_r    <= nz_o_r;
      a_w_r     <= IW'(a_o_r);
      c_w_r     <= IW'(a_o_r + (2*CW+1)'(v_eff) + (2*CW+1)'(1));
    end
  end

  // emitter: one vertex result, then six indices for a cell point
  logic          hold_r, hold_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          grid_e_r;
  logic [PW-1:0] e_px_r, e_py_r, e_pz_r;
  logic [NW-1:0] e_nx_r, e_ny_r, e_nz_r;
  logic [XW-1:0] e_ts_r, e_tt_r;
  logic [IW-1:0] e_a_r, e_c_r;
  logic          cur_last, fire, load, is_vtx;
  logic [1:0]    csel;
  logic [IW-1:0] idx;

  assign is_vtx    = (cnt_r == 3'd0);
  assign cur_last  = is_vtx ? !grid_e_r : (cnt_r == 3'd6);
  assign fire      = hold_r && out_ch.ready;
  assign emit_take = !hold_r || (fire && cur_last);
  assign load      = en && vld_r[ST_W];

  always_comb begin
    hold_nxt = hold_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      hold_nxt = 1'b1;
      cnt_nxt  = 3'd0;
    end else if (fire) begin
      if (cur_last) begin
        hold_nxt = 1'b0;
        cnt_nxt  = 3'd0;
      end else begin
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      hold_r <= hold_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grid_e_r <= side_r[ST_W].in_grid;
      e_px_r   <= pos_x_w_r;
      e_py_r   <= pos_y_w_r;
      e_pz_r   <= pos_z_w_r;
      e_nx_r   <= nx_w_r;
      e_ny_r   <= ny_w_r;
      e_nz_r   <= nz_w_r;
      e_ts_r   <= side_r[ST_W].tex_s;
      e_tt_r   <= side_r[ST_W].tex_t;
      e_a_r    <= a_w_r;
      e_c_r    <= c_w_r;
    end
  end

  assign csel = corner_sel(rev_wind_r, cnt_r - 3'd1);

  always_comb begin
    case (csel)
      2'd0:    idx = e_a_r;
      2'd1:    idx = e_a_r + IW'(1);
      2'd2:    idx = e_c_r;
      default: idx = e_c_r + IW'(1);
    endcase
  end

  assign out_ch.valid        = hold_r;
  assign out_ch.kind         = is_vtx ? usm_pkg::KIND_VERTEX : usm_pkg::KIND_INDEX;
  assign out_ch.pos_x        = is_vtx ? $signed(e_px_r) : '0;
  assign out_ch.pos_y        = is_vtx ? $signed(e_py_r) : '0;
  assign out_ch.pos_z        = is_vtx ? $signed(e_pz_r) : '0;
  assign out_ch.normal_x     = is_vtx ? $signed(e_nx_r) : '0;
  assign out_ch.normal_y     = is_vtx ? $signed(e_ny_r) : '0;
  assign out_ch.normal_z     = is_vtx ? $signed(e_nz_r) : '0;
  assign out_ch.tex_s        = is_vtx ? e_ts_r : '0;
  assign out_ch.tex_t        = is_vtx ? e_tt_r : '0;
  assign out_ch.vertex_index = is_vtx ? '0 : idx;
  assign out_ch.last         = cur_last;

endmodule

// File: bench/uv_sphere_mesh_point_top_tb.sv
// self-checking testbench for the uv sphere mesh point block
module uv_sphere_mesh_point_top_tb;

  // result item as seen on the output channel
  typedef struct {
    logic                      kind;
    logic [usm_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
    logic [usm_pkg::NRM_W-1:0] normal_x, normal_y, normal_z;
    logic [usm_pkg::TEX_W-1:0] tex_s, tex_t;
    logic [usm_pkg::IDX_W-1:0] vertex_index;
    logic                      last;
  } mesh_res_t;

  // one register setting of the sphere
  typedef struct {
    int unsigned seg_u, seg_v, rad;
    bit ms, mt, inw, rev;
  } sphere_cfg_t;

  // directed row: typed values only where they are obvious by hand
  typedef struct {
    int unsigned col, row;
    bit          typed;
    int unsigned ts, tt;
    bit          is_cell;
    int unsigned corner_a;
  } point_row_t;

  localparam longint unsigned Q30_ONE  = 64'd1 << 30;
  localparam longint unsigned Q30_HPI  = 64'd1686629713;
  localparam logic [usm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int N_CFG  = 7;
  localparam int N_ROWS = 16;
  localparam int N_RAND = 49;
  localparam int DRAIN  = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [usm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [usm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  usm_in_if  in_if ();
  usm_out_if out_if ();

  uv_sphere_mesh_point_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // shadow copy of the block registers
  sphere_cfg_t shadow;
  mesh_res_t   pending_res[$];
  int          fail_cnt = 0;
  int          send_idle = 0;   // percent of cycles the sender holds back
  int          recv_stall = 0;  // percent of cycles the receiver stalls

  initial begin
    in_if.valid  = 1'b0;
    in_if.column = '0;
    in_if.row    = '0;
    out_if.ready = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // sine of a Q30 residual angle, truncating horner steps
  function automatic longint residual_sin(longint unsigned x);
    longint unsigned dv[6];
    longint unsigned x2, t;
    dv = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    x2 = (x * x + (Q30_ONE >> 1)) >> 30;
    t = Q30_ONE;
    for (int k = 0; k < 6; k++) t = Q30_ONE - (((x2 * t) >> 30) / dv[k]);
    t = (x * t + (Q30_ONE >> 1)) >> 30;
    if (t > Q30_ONE) t = Q30_ONE;
    return longint'(t);
  endfunction

  // sin and cos of the fraction n/d of a full turn, by quadrant
  task automatic turn_sin_cos(input longint unsigned n, input longint unsigned d,
                              output longint sn, output longint cs);
    longint unsigned q, rem, x;
    longint s0, c0;
    q = (4 * n) / d;
    rem = 4 * n - q * d;
    x = (rem * Q30_HPI + d / 2) / d;
    if (x > Q30_HPI) x = Q30_HPI;
    s0 = residual_sin(x);
    c0 = residual_sin(Q30_HPI - x);
    case (q & 3)
      0: begin sn = s0;  cs = c0;  end
      1: begin sn = c0;  cs = -s0; end
      2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
  endtask

  // round half away from zero, then drop sh fraction bits
  function automatic longint round_drop(longint v, int sh);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned seg_count(int unsigned c, int unsigned cap);
    if (c == 0) return 1;
    return (c > cap) ? cap : c;
  endfunction

  // vertex result and, for a cell point, six corner indices
  task automatic predict_point(input int unsigned col, input int unsigned row,
                               output mesh_res_t res[$]);
    longint unsigned u, v, i, j, sn, tn, a, b, c, d;
    longint st, ct, sp, cp, px, pz, nx, ny, nz;
    longint unsigned corner[6];
    mesh_res_t r;
    bit in_grid;
    res = {};
    u = seg_count(shadow.seg_u, usm_pkg::MAX_SEGMENTS_U_DEF);
    v = seg_count(shadow.seg_v, usm_pkg::MAX_SEGMENTS_V_DEF);
    i = (col > u) ? u : col;
    j = (row > v) ? v : row;
    in_grid = (i < u) && (j < v);
    turn_sin_cos(i, u, st, ct);
    turn_sin_cos(j, 2 * v, sp, cp);
    px = round_drop(sp * ct, 30);
    pz = round_drop(sp * st, 30);
    nx = round_drop(sp * ct, 46);
    ny = round_drop(cp, 16);
    nz = round_drop(sp * st, 46);
    if (shadow.inw) begin
      nx = -nx; ny = -ny; nz = -nz;
    end
    sn = shadow.ms ? u - i : i;
    tn = shadow.mt ? v - j : j;
    r = '{default: '0};
    r.kind     = usm_pkg::KIND_VERTEX;
    r.pos_x    = usm_pkg::POS_W'(round_drop(px * longint'(shadow.rad), 30));
    r.pos_y    = usm_pkg::POS_W'(round_drop(cp * longint'(shadow.rad), 30));
    r.pos_z    = usm_pkg::POS_W'(round_drop(pz * longint'(shadow.rad), 30));
    r.normal_x = usm_pkg::NRM_W'(nx);
    r.normal_y = usm_pkg::NRM_W'(ny);
    r.normal_z = usm_pkg::NRM_W'(nz);
    r.tex_s    = usm_pkg::TEX_W'((sn * 131072 + u) / (2 * u));
    r.tex_t    = usm_pkg::TEX_W'((tn * 131072 + v) / (2 * v));
    r.last     = !in_grid;
    res = {res, r};
    if (!in_grid) return;
    a = i * (v + 1) + j;
    b = a + 1;
    c = a + v + 1;
    d = c + 1;
    if (shadow.rev) corner = '{a, b, c, b, d, c};
    else corner = '{a, c, b, b, c, d};
    for (int k = 0; k < 6; k++) begin
      r = '{default: '0};
      r.kind = usm_pkg::KIND_INDEX;
      r.vertex_index = usm_pkg::IDX_W'(corner[k]);
      r.last = (k == 5);
      res = {res, r};
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic cmp_field(string name, longint unsigned want, longint unsigned got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // receiver: random stall, compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    mesh_res_t w;
    out_if.ready <= ($urandom_range(99) >= recv_stall);
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_res.size() == 0) begin
        fail_cnt++;
        $display("%0t unexpected result item: expected none actual kind %0b idx %0h",
                 $time, out_if.kind, out_if.vertex_index);
      end else begin
        w = pending_res.pop_front();
        cmp_field("kind", w.kind, out_if.kind);
        cmp_field("pos_x", w.pos_x, $unsigned(out_if.pos_x));
        cmp_field("pos_y", w.pos_y, $unsigned(out_if.pos_y));
        cmp_field("pos_z", w.pos_z, $unsigned(out_if.pos_z));
        cmp_field("normal_x", w.normal_x, $unsigned(out_if.normal_x));
        cmp_field("normal_y", w.normal_y, $unsigned(out_if.normal_y));
        cmp_field("normal_z", w.normal_z, $unsigned(out_if.normal_z));
        cmp_field("tex_s", w.tex_s, out_if.tex_s);
        cmp_field("tex_t", w.tex_t, out_if.tex_t);
        cmp_field("vertex_index", w.vertex_index, out_if.vertex_index);
        cmp_field("last", w.last, out_if.last);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // present one grid point and hold it until accepted; valid stays up across back-to-back items
  task automatic send_point(int unsigned col, int unsigned row, output mesh_res_t res[$]);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.column <= usm_pkg::CNT_W'(col);
    in_if.row    <= usm_pkg::CNT_W'(row);
    predict_point(col, row, res);
    do @(posedge clk); while (!in_if.ready);
    pending_res = {pending_res, res};
  endtask

  // let the pipeline go fully quiet before touching registers
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_regs(sphere_cfg_t s);
    usm_pkg::cfg_idx_t ix[N_CFG];
    int unsigned val[N_CFG];
    ix  = '{usm_pkg::CFG_SEG_U, usm_pkg::CFG_SEG_V, usm_pkg::CFG_RADIUS,
            usm_pkg::CFG_MIRROR_S, usm_pkg::CFG_MIRROR_T, usm_pkg::CFG_INWARD,
            usm_pkg::CFG_REV_WIND};
    val = '{s.seg_u, s.seg_v, s.rad, s.ms, s.mt, s.inw, s.rev};
    for (int k = 0; k < N_CFG; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= ix[k];
      cfg_data  <= usm_pkg::CFG_DATA_W'(val[k]);
      @(posedge clk);
    end
    // an out-of-range index must leave every register alone
    cfg_index <= CFG_SPARE;
    cfg_data  <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow = s;
  endtask

  initial begin
    point_row_t  rows[N_ROWS];
    sphere_cfg_t phases[7];
    mesh_res_t   got[$];
    longint unsigned ue, ve;
    int unsigned col, row;

    // directed points against the reset setting u=32 v=16
    rows = '{
      '{0,   0,   1, 0,     0,     1, 0},    // north pole, first cell
      '{32,  16,  1, 65536, 65536, 0, 0},    // far corner, edge only
      '{511, 511, 1, 65536, 65536, 0, 0},    // both fields clamped
      '{16,  8,   1, 32768, 32768, 1, 280},  // half turn at the equator
      '{8,   0,   1, 16384, 0,     1, 136},  // quarter turn at the pole
      '{0,   16,  1, 0,     65536, 0, 0},    // south pole edge
      '{32,  0,   1, 65536, 0,     0, 0},    // seam column edge
      '{31,  15,  0, 0, 0, 0, 0},            // last cell
      '{24,  4,   0, 0, 0, 0, 0},
      '{1,   1,   0, 0, 0, 0, 0},
      '{0,   511, 0, 0, 0, 0, 0},
      '{511, 0,   0, 0, 0, 0, 0},
      '{256, 3,   0, 0, 0, 0, 0},
      '{3,   256, 0, 0, 0, 0, 0},
      '{170, 85,  0, 0, 0, 0, 0},
      '{12,  13,  0, 0, 0, 0, 0}
    };
    // register settings, extremes and out-of-range counts among them
    phases = '{
      '{1,   1,   65535, 1, 1, 1, 1},  // single segment, largest radius
      '{256, 256, 1,     0, 1, 0, 1},  // densest grid, tiny radius
      '{0,   3,   0,     1, 0, 1, 0},  // zero count acts as one, zero radius
      '{511, 300, 4660,  0, 0, 1, 1},  // counts saturate at the maximum
      '{7,   5,   65535, 1, 1, 0, 0},
      '{256, 1,   32768, 0, 1, 1, 0},
      '{32,  16,  256,   0, 0, 0, 0}   // back to the reset setting
    };
    shadow = '{32, 16, 256, 0, 0, 0, 0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[n]) begin
      send_point(rows[n].col, rows[n].row, got);
      if (rows[n].typed && (got[0].tex_s != rows[n].ts || got[0].tex_t != rows[n].tt
          || (rows[n].is_cell && got[1].vertex_index != rows[n].corner_a))) begin
        fail_cnt++;
        $display("%0t hand value disagrees at (%0d,%0d): expected %0d %0d %0d actual %0d %0d",
                 $time, rows[n].col, rows[n].row, rows[n].ts, rows[n].tt,
                 rows[n].corner_a, got[0].tex_s, got[0].tex_t);
      end
    end

    foreach (phases[p]) begin
      wait_idle();
      write_regs(phases[p]);
      // cycle through the idling patterns; every fourth stretch has none
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 73; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 73; end
        default: begin send_idle = 34; recv_stall = 34; end
      endcase
      ue = seg_count(shadow.seg_u, usm_pkg::MAX_SEGMENTS_U_DEF);
      ve = seg_count(shadow.seg_v, usm_pkg::MAX_SEGMENTS_V_DEF);
      for (int n = 0; n < N_RAND; n++) begin
        // mostly points on the grid, some beyond it to exercise clamping
        if ($urandom_range(9) < 8) begin
          col = $urandom_range(int'(ue));
          row = $urandom_range(int'(ve));
        end else begin
          col = $urandom_range(511);
          row = $urandom_range(511);
        end
        send_point(col, row, got);
      end
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
